### rtl/dp2w_pkg.sv
package dp2w_pkg;

    // Stream geometry
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int POSE_IDX_W = 4;
    localparam int POSE_WORDS = 12;
    localparam int INV_W      = 24;
    localparam int CENTER_W   = 16;
    localparam int CENTER_FRAC = 4;

    // Arithmetic widths
    localparam int DU_W   = ((COORD_BITS + CENTER_FRAC > CENTER_W) ?
                             COORD_BITS + CENTER_FRAC : CENTER_W) + 1;
    localparam int PX_W   = DU_W + INV_W + 1;
    localparam int ZP_W   = DEPTH_W + INV_W;
    localparam int PROD_W = 2 * WORD_W;
    localparam int WIDE_W = PROD_W + 2;
    localparam int TERM_W = PROD_W - FRAC_BITS + 1;
    localparam int Z_SHIFT = INV_W - FRAC_BITS;
    localparam int R_SHIFT = INV_W + CENTER_FRAC - FRAC_BITS;

    // Input tdata layout, lowest field first
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_BITS;
    localparam int DEPTH_LSB = ROW_LSB + COORD_BITS;
    localparam int BLUE_LSB  = DEPTH_LSB + DEPTH_W;
    localparam int GREEN_LSB = BLUE_LSB + COLOR_W;
    localparam int RED_LSB   = GREEN_LSB + COLOR_W;
    localparam int PIDX_LSB  = RED_LSB + COLOR_W;
    localparam int PVAL_LSB  = PIDX_LSB + POSE_IDX_W;
    localparam int IN_FIELDS_W = PVAL_LSB + WORD_W;
    localparam int S_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_FIELDS_W = 3 * WORD_W + 3 * COLOR_W;
    localparam int M_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DEPTH_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X        = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y        = CFG_IDX_W'(4);

    localparam logic [INV_W-1:0]    INV_DEPTH_SCALE_RST = INV_W'(16777);
    localparam logic [INV_W-1:0]    INV_FOCAL_X_RST     = INV_W'(32388);
    localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST     = INV_W'(32326);
    localparam logic [CENTER_W-1:0] CENTER_X_RST        = CENTER_W'(5208);
    localparam logic [CENTER_W-1:0] CENTER_Y_RST        = CENTER_W'(4056);

    // Item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_POSE  = 1'b1;

    localparam logic signed [WORD_W-1:0] POSE_ONE = WORD_W'(longint'(1) << FRAC_BITS);

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth;
        color_t                color;
        logic [POSE_IDX_W-1:0] pose_index;
        logic [WORD_W-1:0]     pose_value;
    } pix_in_t;

    typedef struct packed {
        logic                  is_pose;
        logic [POSE_IDX_W-1:0] pose_index;
        logic [WORD_W-1:0]     pose_value;
    } pose_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        pose_wr_t pw;
        point_t   cam;
        color_t   color;
    } cam_item_t;

    // Add half, then arithmetic shift: round half up
    function automatic logic signed [WIDE_W-1:0] round_sh(input logic signed [WIDE_W-1:0] v,
                                                          input int unsigned s);
        logic signed [WIDE_W-1:0] half;
        logic signed [WIDE_W-1:0] sum;
        half = (WIDE_W'(1) << s) >> 1;
        sum  = v + half;
        return sum >>> s;
    endfunction

    // Clamp to a signed word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-WORD_W:0] top;
        top = v[WIDE_W-1:WORD_W-1];
        priority if (&top || ~|top) begin
            return v[WORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

### rtl/dp2w_back.sv
module dp2w_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dp2w_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dp2w_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dp2w_pkg::pix_in_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dp2w_pkg::cam_item_t           out_item
);
    import dp2w_pkg::*;

    logic [INV_W-1:0]    inv_ds_reg;
    logic [INV_W-1:0]    inv_fx_reg;
    logic [INV_W-1:0]    inv_fy_reg;
    logic [CENTER_W-1:0] cx_reg;
    logic [CENTER_W-1:0] cy_reg;

    // Stage a: raw products
    logic                     va_reg, va_next;
    pose_wr_t                 pwa_reg, pwa_next;
    color_t                   cola_reg;
    logic [ZP_W-1:0]          zp_reg, zp_next;
    logic signed [PX_W-1:0]   pxp_reg, pxp_next, pyp_reg, pyp_next;
    logic signed [DU_W-1:0]   du, dv;

    // Stage b: rounded z and ray slopes
    logic                     vb_reg;
    pose_wr_t                 pwb_reg;
    color_t                   colb_reg;
    logic signed [WORD_W-1:0] zb_reg, zb_next, rx_reg, rx_next, ry_reg, ry_next;

    // Stage c: slope times depth
    logic                     vc_reg;
    pose_wr_t                 pwc_reg;
    color_t                   colc_reg;
    logic signed [WORD_W-1:0] zc_reg;
    logic signed [PROD_W-1:0] pxz_reg, pxz_next, pyz_reg, pyz_next;

    // Stage d: camera point
    logic                     vd_reg;
    cam_item_t                d_reg, d_next;

    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d = !vd_reg || out_ready;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_ds_reg <= INV_DEPTH_SCALE_RST;
            inv_fx_reg <= INV_FOCAL_X_RST;
            inv_fy_reg <= INV_FOCAL_Y_RST;
            cx_reg     <= CENTER_X_RST;
            cy_reg     <= CENTER_Y_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INV_DEPTH_SCALE: inv_ds_reg <= cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_X:     inv_fx_reg <= cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y:     inv_fy_reg <= cfg_wdata[INV_W-1:0];
                CFG_CENTER_X:        cx_reg     <= cfg_wdata[CENTER_W-1:0];
                CFG_CENTER_Y:        cy_reg     <= cfg_wdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // zero depth pixels are dropped at the door
        va_next = in_valid && ((in_item.operation == OP_POSE) || (in_item.depth != '0));
        pwa_next.is_pose    = (in_item.operation == OP_POSE);
        pwa_next.pose_index = in_item.pose_index;
        pwa_next.pose_value = in_item.pose_value;
        du = DU_W'({in_item.column, {CENTER_FRAC{1'b0}}}) - DU_W'(cx_reg);
        dv = DU_W'({in_item.row, {CENTER_FRAC{1'b0}}}) - DU_W'(cy_reg);
        zp_next  = ZP_W'(in_item.depth) * ZP_W'(inv_ds_reg);
        pxp_next = PX_W'(du) * PX_W'($signed({1'b0, inv_fx_reg}));
        pyp_next = PX_W'(dv) * PX_W'($signed({1'b0, inv_fy_reg}));

        zb_next = sat_word(round_sh(WIDE_W'(zp_reg), Z_SHIFT));
        rx_next = sat_word(round_sh(WIDE_W'(pxp_reg), R_SHIFT));
        ry_next = sat_word(round_sh(WIDE_W'(pyp_reg), R_SHIFT));

        pxz_next = PROD_W'(rx_reg) * PROD_W'(zb_reg);
        pyz_next = PROD_W'(ry_reg) * PROD_W'(zb_reg);

        d_next.pw    = pwc_reg;
        d_next.color = colc_reg;
        d_next.cam.x = sat_word(round_sh(WIDE_W'(pxz_reg), FRAC_BITS));
        d_next.cam.y = sat_word(round_sh(WIDE_W'(pyz_reg), FRAC_BITS));
        d_next.cam.z = zc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= va_next;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            pwa_reg  <= pwa_next;
            cola_reg <= in_item.color;
            zp_reg   <= zp_next;
            pxp_reg  <= pxp_next;
            pyp_reg  <= pyp_next;
        end
        if (rdy_b) begin
            pwb_reg  <= pwa_reg;
            colb_reg <= cola_reg;
            zb_reg   <= zb_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
        end
        if (rdy_c) begin
            pwc_reg  <= pwb_reg;
            colc_reg <= colb_reg;
            zc_reg   <= zb_reg;
            pxz_reg  <= pxz_next;
            pyz_reg  <= pyz_next;
        end
        if (rdy_d) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_item  = d_reg;

`ifndef SYNTHESIS
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> va_reg)
        else $error("input held off while first stage empty");

    a_depth_not_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_item.pw.is_pose |-> !out_item.cam.z[WORD_W-1])
        else $error("camera depth came out negative");

    a_stage_c_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg && !rdy_c |=> vc_reg && $stable(pxz_reg) && $stable(pyz_reg))
        else $error("stalled product stage lost its contents");
`endif

endmodule

### rtl/dp2w_xform.sv
module dp2w_xform (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  dp2w_pkg::cam_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output dp2w_pkg::point_t    out_point,
    output dp2w_pkg::color_t    out_color
);
    import dp2w_pkg::*;

    logic signed [WORD_W-1:0] pose_reg [POSE_WORDS];

    // Stage e: nine rotation products
    logic                     ve_reg;
    logic [8:0][PROD_W-1:0]   prod_reg, prod_next;
    logic [2:0][WORD_W-1:0]   te_reg;
    color_t                   cole_reg;

    // Stage f: rounded terms
    logic                     vf_reg;
    logic [8:0][TERM_W-1:0]   term_reg, term_next;
    logic [2:0][WORD_W-1:0]   tf_reg;
    color_t                   colf_reg;

    // Stage g: output register
    logic                     vg_reg;
    point_t                   pt_reg, pt_next;
    color_t                   colg_reg;

    logic                     rdy_e, rdy_f, rdy_g;
    logic                     pose_we;
    logic [2:0][WORD_W-1:0]   cam;
    logic signed [WIDE_W-1:0] acc [3];

    assign rdy_g = !vg_reg || out_ready;
    assign rdy_f = !vf_reg || rdy_g;
    assign rdy_e = !ve_reg || rdy_f;
    assign in_ready = rdy_e;

    // Pose words change in stream order: earlier pixels have already taken their products
    assign pose_we = in_valid && rdy_e && in_item.pw.is_pose &&
                     (in_item.pw.pose_index < POSE_IDX_W'(POSE_WORDS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POSE_WORDS; i++) begin
                pose_reg[i] <= (i == 0 || i == 4 || i == 8) ? POSE_ONE : '0;
            end
        end else if (pose_we) begin
            pose_reg[in_item.pw.pose_index] <= in_item.pw.pose_value;
        end
    end

    always_comb begin
        cam[0] = in_item.cam.x;
        cam[1] = in_item.cam.y;
        cam[2] = in_item.cam.z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i*3+j] = PROD_W'(pose_reg[i*3+j]) * PROD_W'($signed(cam[j]));
            end
        end
        for (int k = 0; k < 9; k++) begin
            term_next[k] = TERM_W'(round_sh(WIDE_W'($signed(prod_reg[k])), FRAC_BITS));
        end
        for (int i = 0; i < 3; i++) begin
            acc[i] = WIDE_W'($signed(term_reg[i*3])) + WIDE_W'($signed(term_reg[i*3+1]))
                   + WIDE_W'($signed(term_reg[i*3+2])) + WIDE_W'($signed(tf_reg[i]));
        end
        pt_next.x = sat_word(acc[0]);
        pt_next.y = sat_word(acc[1]);
        pt_next.z = sat_word(acc[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else begin
            // pose transfers end here
            if (rdy_e) ve_reg <= in_valid && !in_item.pw.is_pose;
            if (rdy_f) vf_reg <= ve_reg;
            if (rdy_g) vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_e) begin
            prod_reg <= prod_next;
            te_reg   <= {pose_reg[11], pose_reg[10], pose_reg[9]};
            cole_reg <= in_item.color;
        end
        if (rdy_f) begin
            term_reg <= term_next;
            tf_reg   <= te_reg;
            colf_reg <= cole_reg;
        end
        if (rdy_g) begin
            pt_reg   <= pt_next;
            colg_reg <= colf_reg;
        end
    end

    assign out_valid = vg_reg;
    assign out_point = pt_reg;
    assign out_color = colg_reg;

`ifndef SYNTHESIS
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> ve_reg)
        else $error("camera points held off while product stage empty");

    a_stage_f_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vf_reg && !rdy_f |=> vf_reg && $stable(term_reg) && $stable(colf_reg))
        else $error("stalled term stage lost its contents");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_point) && $stable(out_color))
        else $error("stalled world point changed before its transfer");
`endif

endmodule

### rtl/depth_pixel_to_world_point_core.sv
// Depth pixel to world point converter.
// s_ channel: one item per transfer. s_tuser selects the kind: a pixel to
// convert, or one word of the stored pose (rotation row-major, then
// translation x y z, signed Q16.16). Pixels with zero depth are consumed and
// give nothing; pose transfers give nothing either.
// m_ channel: one world point per converted pixel, signed Q16.16 x y z,
// saturated, with the pixel colour alongside.
// cfg_ port: reciprocal depth scale, reciprocal focal lengths and principal
// point, written by index; write only while the stream is idle.
// Throughput: one item per clock while m_tready stays high. Seven register
// stages lie between an s_ transfer and m_tvalid (depth and slope products,
// rounding, slope by depth, rounding, rotation products, rounding, sum).
// A pose word takes effect for every pixel that follows it in the stream.
// Reset: empties the pipeline, restores the register defaults and loads an
// identity rotation with zero translation.
// When m_tready is low the result holds and the stages behind it fill up;
// s_tready drops only once every stage is occupied.
module depth_pixel_to_world_point_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dp2w_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dp2w_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // column, row, depth, blue, green, red, pose_index, pose_value, zero fill
    input  logic [dp2w_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // world_x, world_y, world_z, out_blue, out_green, out_red
    output logic [dp2w_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dp2w_pkg::*;

    pix_in_t   in_item;
    cam_item_t cam_item;
    logic      cam_valid, cam_ready;
    point_t    world;
    color_t    color;

    always_comb begin
        in_item.operation   = s_tuser;
        in_item.column      = s_tdata[COL_LSB +: COORD_BITS];
        in_item.row         = s_tdata[ROW_LSB +: COORD_BITS];
        in_item.depth       = s_tdata[DEPTH_LSB +: DEPTH_W];
        in_item.color.blue  = s_tdata[BLUE_LSB +: COLOR_W];
        in_item.color.green = s_tdata[GREEN_LSB +: COLOR_W];
        in_item.color.red   = s_tdata[RED_LSB +: COLOR_W];
        in_item.pose_index  = s_tdata[PIDX_LSB +: POSE_IDX_W];
        in_item.pose_value  = s_tdata[PVAL_LSB +: WORD_W];
    end

    dp2w_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (cam_valid),
        .out_ready (cam_ready),
        .out_item  (cam_item)
    );

    dp2w_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cam_valid),
        .in_ready  (cam_ready),
        .in_item   (cam_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_point (world),
        .out_color (color)
    );

    assign m_tdata = M_TDATA_W'({color.red, color.green, color.blue,
                                 world.z, world.y, world.x});

endmodule

### tb/world_point_checker.sv
module world_point_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dp2w_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dp2w_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // column, row, depth, blue, green, red, pose_index, pose_value, zero fill
    input  logic [dp2w_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // world_x, world_y, world_z, out_blue, out_green, out_red
    input  logic [dp2w_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              mismatches,
    output int                              points_pending
);
    import dp2w_pkg::*;

    localparam int DEPTH_SHIFT = INV_W - FRAC_BITS;
    localparam int SLOPE_SHIFT = INV_W + CENTER_FRAC - FRAC_BITS;
    localparam longint WORD_MAX = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (WORD_W - 1));

    typedef struct packed {
        logic [2:0][WORD_W-1:0] world;
        logic [COLOR_W-1:0]     red;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     blue;
    } world_point_t;

    logic [INV_W-1:0]           inv_depth_scale;
    logic [INV_W-1:0]           inv_focal_x;
    logic [INV_W-1:0]           inv_focal_y;
    logic [CENTER_W-1:0]        center_x;
    logic [CENTER_W-1:0]        center_y;
    logic signed [WORD_W-1:0]   pose_words [POSE_WORDS];
    world_point_t               expected_points [$];
    string                      axis_name [3] = '{"world_x", "world_y", "world_z"};

    function automatic longint round_half_up(input longint v, input int unsigned s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Back-project one pixel through the pinhole model, then apply the pose
    function automatic world_point_t project_pixel(input logic [COORD_BITS-1:0] col,
                                                   input logic [COORD_BITS-1:0] row,
                                                   input logic [DEPTH_W-1:0]    depth,
                                                   input logic [COLOR_W-1:0]    blue,
                                                   input logic [COLOR_W-1:0]    green,
                                                   input logic [COLOR_W-1:0]    red);
        longint       z;
        longint       du;
        longint       dv;
        longint       slope_x;
        longint       slope_y;
        longint       acc;
        longint       cam [3];
        world_point_t pt;
        z = longint'(depth) * longint'(inv_depth_scale);
        if (DEPTH_SHIFT > 0) begin
            z = round_half_up(z, DEPTH_SHIFT);
        end
        z = clamp_word(z);
        du = (longint'(col) <<< CENTER_FRAC) - longint'(center_x);
        dv = (longint'(row) <<< CENTER_FRAC) - longint'(center_y);
        slope_x = clamp_word(round_half_up(du * longint'(inv_focal_x), SLOPE_SHIFT));
        slope_y = clamp_word(round_half_up(dv * longint'(inv_focal_y), SLOPE_SHIFT));
        cam[0] = clamp_word(round_half_up(slope_x * z, FRAC_BITS));
        cam[1] = clamp_word(round_half_up(slope_y * z, FRAC_BITS));
        cam[2] = z;
        for (int i = 0; i < 3; i++) begin
            acc = longint'(pose_words[9 + i]);
            for (int j = 0; j < 3; j++) begin
                acc += round_half_up(longint'(pose_words[3 * i + j]) * cam[j], FRAC_BITS);
            end
            pt.world[i] = WORD_W'(clamp_word(acc));
        end
        pt.blue  = blue;
        pt.green = green;
        pt.red   = red;
        return pt;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        world_point_t            want;
        world_point_t            fresh;
        logic [POSE_IDX_W-1:0]   idx;
        if (!aresetn) begin
            inv_depth_scale = INV_DEPTH_SCALE_RST;
            inv_focal_x     = INV_FOCAL_X_RST;
            inv_focal_y     = INV_FOCAL_Y_RST;
            center_x        = CENTER_X_RST;
            center_y        = CENTER_Y_RST;
            foreach (pose_words[k]) begin
                pose_words[k] = '0;
            end
            pose_words[0] = POSE_ONE;
            pose_words[4] = POSE_ONE;
            pose_words[8] = POSE_ONE;
            expected_points.delete();
        end else begin
            // Retire the oldest point before queueing a new one
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $error("world point with no pixel pending: world_x %0d",
                           $signed(m_tdata[WORD_W-1:0]));
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        compare_field(axis_name[a], longint'($signed(want.world[a])),
                                      longint'($signed(m_tdata[a*WORD_W +: WORD_W])));
                    end
                    compare_field("out_blue", longint'(want.blue),
                                  longint'(m_tdata[3*WORD_W +: COLOR_W]));
                    compare_field("out_green", longint'(want.green),
                                  longint'(m_tdata[3*WORD_W + COLOR_W +: COLOR_W]));
                    compare_field("out_red", longint'(want.red),
                                  longint'(m_tdata[3*WORD_W + 2*COLOR_W +: COLOR_W]));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INV_DEPTH_SCALE: inv_depth_scale = cfg_wdata[INV_W-1:0];
                    CFG_INV_FOCAL_X:     inv_focal_x     = cfg_wdata[INV_W-1:0];
                    CFG_INV_FOCAL_Y:     inv_focal_y     = cfg_wdata[INV_W-1:0];
                    CFG_CENTER_X:        center_x        = cfg_wdata[CENTER_W-1:0];
                    CFG_CENTER_Y:        center_y        = cfg_wdata[CENTER_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_POSE) begin
                    idx = s_tdata[PIDX_LSB +: POSE_IDX_W];
                    if (idx < POSE_WORDS) begin
                        pose_words[idx] = s_tdata[PVAL_LSB +: WORD_W];
                    end
                end else if (s_tdata[DEPTH_LSB +: DEPTH_W] != '0) begin
                    fresh = project_pixel(s_tdata[COL_LSB +: COORD_BITS],
                                          s_tdata[ROW_LSB +: COORD_BITS],
                                          s_tdata[DEPTH_LSB +: DEPTH_W],
                                          s_tdata[BLUE_LSB +: COLOR_W],
                                          s_tdata[GREEN_LSB +: COLOR_W],
                                          s_tdata[RED_LSB +: COLOR_W]);
                    expected_points.insert(expected_points.size(), fresh);
                end
            end
        end
        points_pending <= expected_points.size();
    end

endmodule

### tb/tb.sv
module tb;
    import dp2w_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 20;
    localparam int QUIET_LIMIT     = 5000;
    localparam int MAX_GAP         = 64;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 178;

    localparam logic [POSE_IDX_W-1:0] ROT_XX  = POSE_IDX_W'(0);
    localparam logic [POSE_IDX_W-1:0] ROT_YY  = POSE_IDX_W'(4);
    localparam logic [POSE_IDX_W-1:0] ROT_ZZ  = POSE_IDX_W'(8);
    localparam logic [POSE_IDX_W-1:0] TRANS_X = POSE_IDX_W'(9);
    localparam logic [POSE_IDX_W-1:0] TRANS_Y = POSE_IDX_W'(10);
    localparam int ROT_WORDS = 9;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int          mismatches;
    int          points_pending;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          quiet_cycles   = 0;

    always #HALF_PERIOD aclk = ~aclk;

    depth_pixel_to_world_point_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    world_point_checker point_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_fields(input logic [COORD_BITS-1:0] col,
                                                         input logic [COORD_BITS-1:0] row,
                                                         input logic [DEPTH_W-1:0]    depth,
                                                         input logic [COLOR_W-1:0]    blue,
                                                         input logic [COLOR_W-1:0]    green,
                                                         input logic [COLOR_W-1:0]    red,
                                                         input logic [POSE_IDX_W-1:0] idx,
                                                         input logic [WORD_W-1:0]     value);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[COL_LSB +: COORD_BITS]  = col;
        d[ROW_LSB +: COORD_BITS]  = row;
        d[DEPTH_LSB +: DEPTH_W]   = depth;
        d[BLUE_LSB +: COLOR_W]    = blue;
        d[GREEN_LSB +: COLOR_W]   = green;
        d[RED_LSB +: COLOR_W]     = red;
        d[PIDX_LSB +: POSE_IDX_W] = idx;
        d[PVAL_LSB +: WORD_W]     = value;
        return d;
    endfunction

    // Hold valid high across back-to-back transfers; drop it only for a gap
    task automatic push_item(input logic op, input logic [S_TDATA_W-1:0] data);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row,
                              input logic [DEPTH_W-1:0]    depth,
                              input logic [COLOR_W-1:0]    blue,
                              input logic [COLOR_W-1:0]    green,
                              input logic [COLOR_W-1:0]    red);
        push_item(OP_PIXEL, pack_fields(col, row, depth, blue, green, red,
                                        POSE_IDX_W'($urandom), WORD_W'($urandom)));
    endtask

    // Pixel fields of a pose transfer are noise the block must ignore
    task automatic send_pose(input logic [POSE_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        push_item(OP_POSE, pack_fields(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                       DEPTH_W'($urandom), COLOR_W'($urandom),
                                       COLOR_W'($urandom), COLOR_W'($urandom), idx, value));
    endtask

    // Full pose: rotation terms within plus or minus one, translation within plus or minus 32
    task automatic load_pose();
        for (int k = 0; k < POSE_WORDS; k++) begin
            if (k < ROT_WORDS) begin
                send_pose(POSE_IDX_W'(k),
                          WORD_W'($urandom_range(0, 1 << (FRAC_BITS + 1))) -
                          WORD_W'(1 << FRAC_BITS));
            end else begin
                send_pose(POSE_IDX_W'(k),
                          WORD_W'($urandom_range(0, 1 << (FRAC_BITS + 6))) -
                          WORD_W'(1 << (FRAC_BITS + 5)));
            end
        end
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (points_pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [INV_W-1:0]    inv_depth,
                              input logic [INV_W-1:0]    inv_fx,
                              input logic [INV_W-1:0]    inv_fy,
                              input logic [CENTER_W-1:0] cx,
                              input logic [CENTER_W-1:0] cy);
        // An index past the last register must change nothing
        write_reg(CFG_IDX_W'($urandom_range(CFG_CENTER_Y + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        write_reg(CFG_INV_DEPTH_SCALE, CFG_DATA_W'(inv_depth));
        write_reg(CFG_INV_FOCAL_X, CFG_DATA_W'(inv_fx));
        write_reg(CFG_INV_FOCAL_Y, CFG_DATA_W'(inv_fy));
        write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned         roll;
        logic [WORD_W-1:0]   word;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_stream();
                case (p)
                    1: set_config('1, '1, '1, '1, '1);
                    2: set_config('0, '0, '0, '0, '0);
                    3: set_config(INV_W'(1), INV_W'(1), INV_W'(1), '1, '0);
                    default: set_config(INV_W'($urandom) >> $urandom_range(0, INV_W - 1),
                                        INV_W'($urandom) >> $urandom_range(0, INV_W - 1),
                                        INV_W'($urandom) >> $urandom_range(0, INV_W - 1),
                                        CENTER_W'($urandom), CENTER_W'($urandom));
                endcase
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (p == 0) begin
                send_pixel('0, '0, '1, '0, '0, '0);
                send_pixel('1, '1, DEPTH_W'(1), '1, '1, '1);
                send_pixel(COORD_BITS'(325), COORD_BITS'(253), DEPTH_W'(1000),
                           COLOR_W'(1), COLOR_W'(2), COLOR_W'(3));
                send_pixel('1, '1, '0, '1, '1, '1);
                send_pose(POSE_IDX_W'(POSE_WORDS), '1);
                send_pose('1, WORD_W'(32'h1234_5678));
                send_pixel(COORD_BITS'(640), COORD_BITS'(480), DEPTH_W'(1234),
                           COLOR_W'(8'hAA), COLOR_W'(8'h55), COLOR_W'(8'hF0));
                // Extreme pose words drive every world axis into saturation
                send_pose(ROT_XX, WORD_W'(32'h7FFF_FFFF));
                send_pose(ROT_YY, WORD_W'(32'h8000_0000));
                send_pose(ROT_ZZ, WORD_W'(32'h7FFF_FFFF));
                send_pose(TRANS_X, WORD_W'(32'h7FFF_FFFF));
                send_pose(TRANS_Y, WORD_W'(32'h8000_0000));
                send_pixel('1, '0, '1, '0, '1, '0);
                send_pixel('0, '1, '1, '1, '0, '1);
                send_pose(ROT_XX, POSE_ONE);
                send_pose(ROT_YY, POSE_ONE);
                send_pose(ROT_ZZ, POSE_ONE);
                send_pose(TRANS_X, '0);
                send_pose(TRANS_Y, '0);
                send_pixel(COORD_BITS'(100), COORD_BITS'(400), DEPTH_W'(2500),
                           COLOR_W'(7), COLOR_W'(77), COLOR_W'(177));
            end
            load_pose();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 2) begin
                    load_pose();
                end else if (roll < 10) begin
                    if ($urandom_range(99) < 85) begin
                        word = WORD_W'($urandom_range(0, 1 << (FRAC_BITS + 2))) -
                               WORD_W'(1 << (FRAC_BITS + 1));
                    end else begin
                        word = WORD_W'($urandom);
                    end
                    send_pose(POSE_IDX_W'($urandom), word);
                end else if (roll < 18) begin
                    send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom), '0,
                               COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
                end else begin
                    send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
                               DEPTH_W'($urandom) >> $urandom_range(0, DEPTH_W - 1),
                               COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
                end
            end
        end
        drain_stream();
        if (mismatches == 0 && points_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
